[rtl/button_debounce_short_long_press_core_assert.svh]
// Assertion macros for the button debouncer core.
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_CORE_ASSERT_SVH

`ifndef SYNTH
// Property sampled on clk_i, disabled while rst_ni is low.
`define BDSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bdsl assertion failed");
// Implication form: when ante holds, cons holds in the same cycle.
`define BDSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdsl assertion failed");
// Implication form: when ante holds, cons holds in the next cycle.
`define BDSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdsl assertion failed");
`else
`define BDSL_ASSERT(lbl, prop)
`define BDSL_ASSERT_IMP(lbl, ante, cons)
`define BDSL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/bdsl_pkg.sv]
// Shared constants for the button debouncer core.
`timescale 1ns / 1ps
`default_nettype none
package bdsl_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;

  // Register indexes on the config port.
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 1'b1;

  // Register reset values.
  localparam logic [CfgW-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CfgW-1:0] LONG_PRESS_RST = 16'd1000;

endpackage
`default_nettype wire

[rtl/bdsl_if.sv]
// Valid/ready channel interfaces for update words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface bdsl_in_if
  import bdsl_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             raw_pressed;
  logic [TimeW-1:0] time_ms;
  logic             consume_short;
  logic             consume_long;

  modport source (output valid, output raw_pressed, output time_ms,
                  output consume_short, output consume_long, input ready);
  modport sink   (input valid, input raw_pressed, input time_ms,
                  input consume_short, input consume_long, output ready);
endinterface

interface bdsl_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic stable_level;

  modport source (output valid, output short_press, output long_press,
                  output stable_level, input ready);
  modport sink   (input valid, input short_press, input long_press,
                  input stable_level, output ready);
endinterface
`default_nettype wire

[rtl/button_debounce_short_long_press_core.sv]
// Button debouncer with short and long press events: top level.
`timescale 1ns / 1ps
`default_nettype none
// Takes one update word per clock cycle and returns one result word per
// update, in order. An update is captured in an input register, the
// debounce/press logic runs in one combinational pass, and the result lands
// in an output register. The single pass (two 32-bit wrapping
// subtracts against the stored change and press times, then compares to the
// 16-bit thresholds) sets the one-per-cycle rate. Backpressure on the result
// side stalls the input register; the input side keeps taking words as long
// as the output register is free or being drained. Config writes go straight
// to the threshold registers and must only happen while no update is in
// flight. Reset assumes the button is released.
`include "button_debounce_short_long_press_core_assert.svh"
module button_debounce_short_long_press_core
  import bdsl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  bdsl_in_if.sink                 in_if,
  bdsl_out_if.source              out_if,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  // Threshold registers
  logic [CfgW-1:0] debounce_q, long_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      long_ms_q  <= LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE:   debounce_q <= cfg_wdata_i;
        REG_LONG_PRESS: long_ms_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  logic             in_valid_q;
  logic             in_raw_q, in_cs_q, in_cl_q;
  logic [TimeW-1:0] in_time_q;
  logic             out_valid_q;
  logic             adv;

  // adv: the captured word is processed and its result is loaded
  assign adv         = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_raw_q  <= in_if.raw_pressed;
      in_time_q <= in_if.time_ms;
      in_cs_q   <= in_if.consume_short;
      in_cl_q   <= in_if.consume_long;
    end
  end

  // Debounce and press state
  logic             stable_q, last_raw_q, long_rep_q, short_pend_q, long_pend_q;
  logic [TimeW-1:0] last_change_q, press_start_q;

  logic             raw_edge, settled, flip, press_flip;
  logic [TimeW-1:0] since_change, since_press, held;
  logic             stable_d, long_rep_mid, short_set, long_set;
  logic             short_new, long_new;
  logic [TimeW-1:0] press_start_d, last_change_d;
  logic [TimeW-1:0] debounce_ext, long_ms_ext;

  assign debounce_ext = {{(TimeW-CfgW){1'b0}}, debounce_q};
  assign long_ms_ext  = {{(TimeW-CfgW){1'b0}}, long_ms_q};

  always_comb begin
    raw_edge     = in_raw_q != last_raw_q;
    since_change = in_time_q - last_change_q;
    since_press  = in_time_q - press_start_q;
    // on a raw edge the settle window restarts at zero
    settled      = raw_edge ? (debounce_q == '0) : (since_change >= debounce_ext);
    flip         = settled && (in_raw_q != stable_q);
    press_flip   = flip && in_raw_q;
    stable_d     = flip ? in_raw_q : stable_q;

    last_change_d = raw_edge ? in_time_q : last_change_q;

    press_start_d = press_start_q;
    if (flip) begin
      press_start_d = in_raw_q ? in_time_q : '0;
    end
    long_rep_mid = press_flip ? 1'b0 : long_rep_q;

    // release before the long-press time, no long press seen
    short_set = flip && !in_raw_q && !long_rep_q && (since_press < long_ms_ext);

    // a fresh press has zero hold time
    held     = press_flip ? '0 : since_press;
    long_set = settled && stable_d && !long_rep_mid && (held >= long_ms_ext);

    short_new = short_pend_q || short_set;
    long_new  = long_pend_q || long_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q      <= 1'b0;
      last_raw_q    <= 1'b0;
      last_change_q <= '0;
      press_start_q <= '0;
      long_rep_q    <= 1'b0;
      short_pend_q  <= 1'b0;
      long_pend_q   <= 1'b0;
    end else if (adv) begin
      stable_q      <= stable_d;
      last_raw_q    <= in_raw_q;
      last_change_q <= last_change_d;
      press_start_q <= press_start_d;
      long_rep_q    <= long_rep_mid || long_set;
      // report first, then consume
      short_pend_q  <= short_new && !in_cs_q;
      long_pend_q   <= long_new && !in_cl_q;
    end
  end

  // Output register
  logic short_q, long_q, level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      short_q <= short_new;
      long_q  <= long_new;
      level_q <= stable_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.short_press  = short_q;
  assign out_if.long_press   = long_q;
  assign out_if.stable_level = level_q;

  // Checks
  `BDSL_ASSERT_NXT(a_result_after_adv, adv, out_valid_q)
  `BDSL_ASSERT_NXT(a_state_holds_on_stall, !adv, $stable(stable_q) && $stable(long_rep_q))
  `BDSL_ASSERT_IMP(a_long_once_per_press, $rose(long_pend_q), long_rep_q)
  `BDSL_ASSERT_IMP(a_short_on_release, $rose(short_pend_q), $fell(stable_q))

endmodule
`default_nettype wire

[dv/button_debounce_short_long_press_core_tb.sv]
// Self-checking testbench for the button debouncer core: directed table, then random presses.
`timescale 1ns / 1ps
module button_debounce_short_long_press_core_tb;
  import bdsl_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned SETTLE_CYCLES = 8;        // margin past the input and output registers
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned HOLD_AT      = 400;       // results seen before the long stall
  localparam int unsigned HOLD_CYCLES  = 200;

  // One update word and one report word, field for field as on the channels.
  typedef struct packed {
    logic             raw_pressed;
    logic [TimeW-1:0] time_ms;
    logic             consume_short;
    logic             consume_long;
  } upd_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic stable_level;
  } rpt_t;

  // Directed table rows: either an update word or a register write.
  typedef enum logic {ROW_UPD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    val;
    upd_t               upd;
    logic               known;   // want holds a hand-typed report
    rpt_t               want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  bdsl_in_if  in_if ();
  bdsl_out_if out_if ();

  button_debounce_short_long_press_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Press predictor: shadow thresholds and debounce/press state.
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0]  deb_ms      = DEBOUNCE_RST;
  logic [CfgW-1:0]  lng_ms      = LONG_PRESS_RST;
  logic             level_q     = 1'b0;   // debounced level
  logic             raw_seen    = 1'b0;   // last raw level
  logic [TimeW-1:0] change_at   = '0;     // time of last raw edge
  logic [TimeW-1:0] press_at    = '0;     // time the debounced press began
  logic             long_seen   = 1'b0;   // long press already flagged this press
  logic             short_evt   = 1'b0;
  logic             long_evt    = 1'b0;

  rpt_t        report_q [$];   // reports owed by the block, oldest first
  int unsigned err_cnt = 0;
  int unsigned rpt_cnt = 0;
  int unsigned cyc_cnt = 0;

  // Sender pacing state.
  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  bit          offering   = 1'b0;

  // Advance the shadow state by one update; report flags before consume clears them.
  function automatic rpt_t predict_report(upd_t u);
    rpt_t             r;
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] held;
    if (u.raw_pressed != raw_seen) begin
      raw_seen  = u.raw_pressed;
      change_at = u.time_ms;
    end
    since_edge = u.time_ms - change_at;   // modular, backward time looks long
    if (since_edge >= TimeW'(deb_ms)) begin
      if (u.raw_pressed != level_q) begin
        level_q = u.raw_pressed;
        if (level_q) begin
          press_at  = u.time_ms;
          long_seen = 1'b0;
        end else begin
          held = u.time_ms - press_at;
          if (!long_seen && held < TimeW'(lng_ms)) short_evt = 1'b1;
          press_at = '0;
        end
      end
      held = u.time_ms - press_at;
      if (level_q && !long_seen && held >= TimeW'(lng_ms)) begin
        long_evt  = 1'b1;
        long_seen = 1'b1;
      end
    end
    r.short_press  = short_evt;
    r.long_press   = long_evt;
    r.stable_level = level_q;
    if (u.consume_short) short_evt = 1'b0;
    if (u.consume_long)  long_evt  = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers.
  // ---------------------------------------------------------------------------
  function automatic row_t upd_row(logic raw, logic [TimeW-1:0] t, logic cs, logic cl);
    row_t r;
    r      = '0;
    r.kind = ROW_UPD;
    r.upd  = '{raw, t, cs, cl};
    return r;
  endfunction

  function automatic row_t known_row(logic raw, logic [TimeW-1:0] t, logic cs, logic cl,
                                     rpt_t want);
    row_t r;
    r       = upd_row(raw, t, cs, cl);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  task automatic drop_valid();
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Bursts of random length, random gaps; steady phases never idle.
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
      if (gap != 0) begin
        drop_valid();
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Offer one word, wait for the handshake, then queue what it should report.
  task automatic send_word(input upd_t u, input logic known, input rpt_t want);
    rpt_t pred;
    in_if.valid         <= 1'b1;
    in_if.raw_pressed   <= u.raw_pressed;
    in_if.time_ms       <= u.time_ms;
    in_if.consume_short <= u.consume_short;
    in_if.consume_long  <= u.consume_long;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    pred = predict_report(u);
    report_q.push_back(known ? want : pred);
    pace();
  endtask

  // Stop offering and let every owed report drain before touching registers.
  task automatic wait_idle();
    drop_valid();
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DEBOUNCE) deb_ms = val;
    else                     lng_ms = val;
  endtask

  // One random phase: a bouncing button with press lengths spread around the
  // long-press time, plus some noise words and backward time steps.
  task automatic run_phase(input int unsigned n, input logic [CfgW-1:0] deb,
                           input logic [CfgW-1:0] lng, input logic [TimeW-1:0] t_start,
                           input bit calm);
    upd_t             u;
    logic             phys;
    logic [TimeW-1:0] t_now;
    logic [TimeW-1:0] t_flip;
    int unsigned      hold_len;
    int unsigned      bounce_left;
    int unsigned      step_max;
    int unsigned      roll;
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lng);
    steady      = calm;
    burst_left  = 0;
    step_max    = (32'(deb) + 32'(lng)) / 12 + 1;
    phys        = 1'b0;
    t_now       = t_start;
    t_flip      = t_start;
    hold_len    = 0;
    bounce_left = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (t_now - t_flip >= hold_len) begin
        phys        = ~phys;
        t_flip      = t_now;
        hold_len    = $urandom_range(0, 2 * 32'(lng) + 2 * 32'(deb) + 4);
        bounce_left = $urandom_range(0, 4);
      end
      u.raw_pressed = phys;
      if (bounce_left != 0) begin
        u.raw_pressed = 1'($urandom_range(0, 1));
        bounce_left--;
      end
      u.time_ms = t_now;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        // noise: arbitrary level at an arbitrary time
        u.raw_pressed = 1'($urandom_range(0, 1));
        u.time_ms     = $urandom();
      end else if (roll < 7) begin
        u.time_ms = t_now - $urandom_range(1, 3 * step_max);
      end
      u.consume_short = ($urandom_range(0, 3) != 0);
      u.consume_long  = ($urandom_range(0, 3) != 0);
      send_word(u, 1'b0, '0);
      t_now = t_now + $urandom_range(0, step_max);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t dir_tab [$];
    in_if.valid         <= 1'b0;
    in_if.raw_pressed   <= 1'b0;
    in_if.time_ms       <= '0;
    in_if.consume_short <= 1'b0;
    in_if.consume_long  <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_DEBOUNCE;
    cfg_wdata_i         <= '0;
    rst_ni              <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_tab = '{
      // reset defaults: debounce 50, long press 1000, released
      known_row(1'b0, 32'd0,   1'b0, 1'b0, '{1'b0, 1'b0, 1'b0}),
      known_row(1'b1, 32'd100, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0}),  // raw edge, not settled
      upd_row  (1'b1, 32'd149, 1'b0, 1'b0),                       // one ms short
      known_row(1'b1, 32'd150, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b1}),  // settles pressed
      upd_row  (1'b0, 32'd400, 1'b0, 1'b0),
      known_row(1'b0, 32'd450, 1'b1, 1'b0, '{1'b1, 1'b0, 1'b0}),  // short, then consumed
      upd_row  (1'b0, 32'd460, 1'b1, 1'b1),
      // long press held, reported twice, then consumed; release gives no short
      upd_row  (1'b1, 32'd1000, 1'b0, 1'b0),
      upd_row  (1'b1, 32'd1050, 1'b0, 1'b0),
      upd_row  (1'b1, 32'd2050, 1'b0, 1'b0),
      upd_row  (1'b1, 32'd3000, 1'b0, 1'b1),
      upd_row  (1'b0, 32'd3100, 1'b0, 1'b0),
      upd_row  (1'b0, 32'd3150, 1'b1, 1'b1),
      // settle across the 32-bit wrap, then time steps backward
      upd_row  (1'b1, 32'hFFFF_FFF0, 1'b0, 1'b0),
      upd_row  (1'b1, 32'h0000_0020, 1'b0, 1'b0),
      upd_row  (1'b1, 32'h0000_0022, 1'b0, 1'b0),
      upd_row  (1'b1, 32'hFFFF_FF00, 1'b0, 1'b0),
      // zero debounce, zero long-press time: every press is long at once
      cfg_row  (REG_DEBOUNCE, 16'd0),
      cfg_row  (REG_LONG_PRESS, 16'd0),
      upd_row  (1'b0, 32'd5, 1'b0, 1'b1),
      upd_row  (1'b1, 32'd6, 1'b1, 1'b0),
      upd_row  (1'b0, 32'd7, 1'b1, 1'b1),
      // largest thresholds
      cfg_row  (REG_DEBOUNCE, 16'hFFFF),
      cfg_row  (REG_LONG_PRESS, 16'hFFFF),
      upd_row  (1'b1, 32'd1000,   1'b0, 1'b0),
      upd_row  (1'b1, 32'd66534,  1'b0, 1'b0),
      upd_row  (1'b1, 32'd66535,  1'b0, 1'b0),
      upd_row  (1'b0, 32'd70000,  1'b0, 1'b0),
      upd_row  (1'b0, 32'd135535, 1'b1, 1'b1)
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].upd, dir_tab[i].known, dir_tab[i].want);
      end
    end

    // Random phases; each one drains and rewrites both thresholds first.
    run_phase(200, 16'd5,  16'd40,  $urandom(), 1'b0);
    run_phase(200, 16'd0,  16'd1,   $urandom(), 1'b0);
    run_phase(200, 16'd20, 16'd200, $urandom(), 1'b1);
    run_phase(200, 16'd3,  16'd15,  $urandom(), 1'b0);
    run_phase(150, 16'($urandom_range(0, 30)), 16'($urandom_range(1, 300)),
              $urandom(), 1'b0);
    run_phase(175, 16'hFFFF, 16'hFFFF, 32'hFFF0_0000, 1'b0);

    wait_idle();
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern is redrawn at random for each window; one long
  // hold-off once enough reports have passed, so the block fills and pushes back.
  // ---------------------------------------------------------------------------
  initial begin : report_sink
    int unsigned win_left;
    int unsigned mode;
    int unsigned hold_left;
    bit          hold_done;
    win_left  = 0;
    mode      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && rpt_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (win_left == 0) begin
        win_left = 64;
        mode     = $urandom_range(0, 3);
      end
      win_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_if.ready <= 1'b1;                        // no stalls
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= (cyc_cnt % 3 != 0);          // periodic stall
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Report checker: every accepted word against the oldest owed report.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : report_check
    rpt_t got;
    rpt_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got     = '{out_if.short_press, out_if.long_press, out_if.stable_level};
      rpt_cnt <= rpt_cnt + 1;
      if (report_q.size() == 0) begin
        $display("%0t: report with none owed, got %b", $time, got);
        err_cnt++;
      end else begin
        want = report_q.pop_front();
        if (got.short_press !== want.short_press) begin
          $display("%0t: short_press exp %0b got %0b", $time, want.short_press,
                   got.short_press);
          err_cnt++;
        end
        if (got.long_press !== want.long_press) begin
          $display("%0t: long_press exp %0b got %0b", $time, want.long_press,
                   got.long_press);
          err_cnt++;
        end
        if (got.stable_level !== want.stable_level) begin
          $display("%0t: stable_level exp %0b got %0b", $time, want.stable_level,
                   got.stable_level);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  initial begin : watchdog
    wait (cyc_cnt >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[button_debounce_short_long_press_core.f]
+incdir+rtl
rtl/bdsl_pkg.sv
rtl/bdsl_if.sv
rtl/button_debounce_short_long_press_core.sv
dv/button_debounce_short_long_press_core_tb.sv
